FILE: hdl/smm_pkg.sv
`timescale 1ns / 1ps

package smm_pkg;

  localparam int MAX_DIM = 8;
  localparam int CELLS   = MAX_DIM * MAX_DIM;
  localparam int ADDR_W  = $clog2(CELLS);
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int CNT_W   = $clog2(MAX_DIM + 1);

  localparam int CMD_W  = 2;
  localparam int ROW_W  = 3;
  localparam int WORD_W = 32;
  localparam int CFG_W  = 4;

  localparam int IN_FIELDS_W  = 2 * ROW_W + WORD_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * ROW_W + WORD_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_W-1:0] SIZE_RESET = CFG_W'(MAX_DIM);

  localparam logic [CMD_W-1:0] CMD_WR_A = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_B = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             rd_first;
    logic             rd_last;
    logic [DIM_W-1:0] i;
    logic [DIM_W-1:0] j;
    logic [DIM_W-1:0] k;
    logic             load_out;
    logic             out_last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic acc_done;
    logic out_free;
  } dp_status_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [DIM_W-1:0] r,
                                                  input logic [DIM_W-1:0] c);
    cell_addr = ADDR_W'(r * MAX_DIM + c);
  endfunction

endpackage

FILE: hdl/smm_ctrl.sv
`timescale 1ns / 1ps

module smm_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_wr_en_i,
  input  logic [smm_pkg::CFG_W-1:0]           cfg_wr_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [smm_pkg::CMD_W-1:0]           in_cmd_i,
  input  smm_pkg::dp_status_t                 status_i,
  output smm_pkg::ctrl_cmd_t                  cmd_o
);

  smm_pkg::state_e                 state_q, state_d;
  logic [smm_pkg::CFG_W-1:0]       size_q;
  logic [smm_pkg::DIM_W-1:0]       i_q, i_d, j_q, j_d, k_q, k_d;
  logic [smm_pkg::CNT_W-1:0]       n_last;
  logic                            in_acc;
  logic                            k_end, j_end, i_end;

  always_comb begin
    if (size_q == '0) begin
      n_last = '0;
    end else if (size_q > smm_pkg::CFG_W'(smm_pkg::MAX_DIM)) begin
      n_last = smm_pkg::CNT_W'(smm_pkg::MAX_DIM - 1);
    end else begin
      n_last = smm_pkg::CNT_W'(size_q - 1'b1);
    end
  end

  assign in_ready_o = (state_q == smm_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign k_end      = (smm_pkg::CNT_W'(k_q) == n_last);
  assign j_end      = (smm_pkg::CNT_W'(j_q) == n_last);
  assign i_end      = (smm_pkg::CNT_W'(i_q) == n_last);

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    k_d     = k_q;

    cmd_o          = '0;
    cmd_o.i        = i_q;
    cmd_o.j        = j_q;
    cmd_o.k        = k_q;
    cmd_o.rd_first = (k_q == '0);
    cmd_o.rd_last  = k_end;
    cmd_o.out_last = i_end && j_end;

    case (state_q)
      smm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_o.wr_a = (in_cmd_i == smm_pkg::CMD_WR_A);
          cmd_o.wr_b = (in_cmd_i == smm_pkg::CMD_WR_B);
          if (in_cmd_i == smm_pkg::CMD_MUL) begin
            i_d     = '0;
            j_d     = '0;
            k_d     = '0;
            state_d = smm_pkg::ST_ISSUE;
          end
        end
      end
      smm_pkg::ST_ISSUE: begin
        cmd_o.rd_en = 1'b1;
        if (k_end) begin
          state_d = smm_pkg::ST_DRAIN;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      smm_pkg::ST_DRAIN: begin
        if (status_i.acc_done && status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          k_d            = '0;
          if (j_end) begin
            j_d = '0;
            if (i_end) begin
              state_d = smm_pkg::ST_IDLE;
            end else begin
              i_d     = i_q + 1'b1;
              state_d = smm_pkg::ST_ISSUE;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = smm_pkg::ST_ISSUE;
          end
        end
      end
      default: begin
        state_d = smm_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smm_pkg::ST_IDLE;
      size_q  <= smm_pkg::SIZE_RESET;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
      if (cfg_wr_en_i) begin
        size_q <= cfg_wr_data_i;
      end
    end
  end

endmodule

FILE: hdl/smm_datapath.sv
`timescale 1ns / 1ps

module smm_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  smm_pkg::ctrl_cmd_t                  cmd_i,
  output smm_pkg::dp_status_t                 status_o,
  input  logic [smm_pkg::ROW_W-1:0]           in_row_i,
  input  logic [smm_pkg::ROW_W-1:0]           in_col_i,
  input  logic [smm_pkg::WORD_W-1:0]          in_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [smm_pkg::ROW_W-1:0]           out_row_o,
  output logic [smm_pkg::ROW_W-1:0]           out_col_o,
  output logic [smm_pkg::WORD_W-1:0]          out_product_o,
  output logic                                out_last_o
);

  logic [smm_pkg::WORD_W-1:0] mem_a [smm_pkg::CELLS];
  logic [smm_pkg::WORD_W-1:0] mem_b [smm_pkg::CELLS];

  logic                         wr_in_range;
  logic [smm_pkg::ADDR_W-1:0]   wr_addr, rd_a_addr, rd_b_addr;
  logic [smm_pkg::WORD_W-1:0]   a_rd_q, b_rd_q, prod_d, prod_q, acc_q;
  logic                         s1_v_q, s1_first_q, s1_last_q;
  logic                         s2_v_q, s2_first_q, s2_last_q;
  logic                         done_q;
  logic                         out_valid_q, out_last_q;
  logic [smm_pkg::ROW_W-1:0]    out_row_q, out_col_q;
  logic [smm_pkg::WORD_W-1:0]   out_prod_q;

  assign wr_in_range = (in_row_i < smm_pkg::ROW_W'(smm_pkg::MAX_DIM - 1)
                        || in_row_i == smm_pkg::ROW_W'(smm_pkg::MAX_DIM - 1))
                    && (in_col_i < smm_pkg::ROW_W'(smm_pkg::MAX_DIM - 1)
                        || in_col_i == smm_pkg::ROW_W'(smm_pkg::MAX_DIM - 1));
  assign wr_addr   = smm_pkg::cell_addr(smm_pkg::DIM_W'(in_row_i),
                                        smm_pkg::DIM_W'(in_col_i));
  assign rd_a_addr = smm_pkg::cell_addr(cmd_i.i, cmd_i.k);
  assign rd_b_addr = smm_pkg::cell_addr(cmd_i.k, cmd_i.j);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && wr_in_range) begin
      mem_a[wr_addr] <= in_value_i;
    end
    a_rd_q <= mem_a[rd_a_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b && wr_in_range) begin
      mem_b[wr_addr] <= in_value_i;
    end
    b_rd_q <= mem_b[rd_b_addr];
  end

  assign prod_d = a_rd_q * b_rd_q;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (s2_v_q) begin
      acc_q <= s2_first_q ? prod_q : acc_q + prod_q;
    end
    if (cmd_i.load_out) begin
      out_row_q  <= smm_pkg::ROW_W'(cmd_i.i);
      out_col_q  <= smm_pkg::ROW_W'(cmd_i.j);
      out_prod_q <= acc_q;
      out_last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s1_first_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_v_q      <= 1'b0;
      s2_first_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_v_q     <= cmd_i.rd_en;
      s1_first_q <= cmd_i.rd_first;
      s1_last_q  <= cmd_i.rd_last;
      s2_v_q     <= s1_v_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      if (cmd_i.load_out) begin
        done_q <= 1'b0;
      end else if (s2_v_q && s2_last_q) begin
        done_q <= 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign status_o.acc_done = done_q;
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_row_o     = out_row_q;
  assign out_col_o     = out_col_q;
  assign out_product_o = out_prod_q;
  assign out_last_o    = out_last_q;

endmodule

FILE: hdl/square_matrix_multiply_unit.sv
`timescale 1ns / 1ps

// Square matrix multiplier for signed 32-bit elements, up to 8 by 8. An input
// item with tuser 0 or 1 writes one element of A or B at the row and column in
// tdata. An item with tuser 2 streams out all n*n elements of C = A * B in
// row-major order (n from the size register, 0 read as 1 and values above 8
// read as 8), each wrapped modulo 2^32, the final one with tlast. One
// multiply-accumulate unit fed by the two element memories walks each dot
// product at one term a cycle; a product run is also held up by output
// stalls. No new item is taken until the run has handed its last element to
// the output register. Only elements written since reset may be read by a
// product; write the size register only while the block is idle.
module square_matrix_multiply_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_wr_en_i,
  input  logic [smm_pkg::CFG_W-1:0]            cfg_wr_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [smm_pkg::IN_DATA_W-1:0]        s_axis_tdata,  // row, col, value
  input  logic [smm_pkg::CMD_W-1:0]            s_axis_tuser,  // cmd
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [smm_pkg::OUT_DATA_W-1:0]       m_axis_tdata,  // out_row, out_col, product
  output logic                                 m_axis_tlast
);

  smm_pkg::ctrl_cmd_t               cmd;
  smm_pkg::dp_status_t              status;
  logic [smm_pkg::ROW_W-1:0]        in_row, in_col, out_row, out_col;
  logic [smm_pkg::WORD_W-1:0]       in_value, out_product;

  assign in_row   = s_axis_tdata[smm_pkg::ROW_W-1:0];
  assign in_col   = s_axis_tdata[2*smm_pkg::ROW_W-1:smm_pkg::ROW_W];
  assign in_value = s_axis_tdata[2*smm_pkg::ROW_W+smm_pkg::WORD_W-1:2*smm_pkg::ROW_W];

  smm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_wr_en_i   (cfg_wr_en_i),
    .cfg_wr_data_i (cfg_wr_data_i),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .in_cmd_i      (s_axis_tuser),
    .status_i      (status),
    .cmd_o         (cmd)
  );

  smm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_row_i      (in_row),
    .in_col_i      (in_col),
    .in_value_i    (in_value),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_product_o (out_product),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = smm_pkg::OUT_DATA_W'({out_product, out_col, out_row});

endmodule
